### rtl/spike_synapse_accumulator_macros.svh
// assertion macros shared by the spike synapse accumulator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SPIKE_SYNAPSE_ACCUMULATOR_MACROS_SVH
`define SPIKE_SYNAPSE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, off during reset
`define SSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssa_pkg.sv
// types and constants of the spike synapse accumulator
// no dependencies; imported by every module of the block
package ssa_pkg;

  localparam int NEURON_W  = 10;
  localparam int SYN_IDX_W = 14;
  localparam int COUNT_W   = 15;
  localparam int WEIGHT_W  = 16;
  localparam int MOD_W     = 16;
  localparam int TOTAL_W   = 32;
  localparam int PROD_W    = WEIGHT_W + MOD_W + 1;
  localparam int FRAC_SH   = 14;
  localparam int SCALED_W  = PROD_W - FRAC_SH;
  // walk position and limit never exceed start + count
  localparam int WALK_W    = 15;
  localparam int SYN_WORD_W = NEURON_W + WEIGHT_W;
  localparam int FAN_WORD_W = SYN_IDX_W + COUNT_W;

  typedef enum logic [2:0] {
    CMD_WR_SYN    = 3'd0,
    CMD_WR_FAN    = 3'd1,
    CMD_SET_INPUT = 3'd2,
    CMD_SPIKE     = 3'd3,
    CMD_READ      = 3'd4
  } ssa_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAN,
    ST_WALK,
    ST_DRAIN,
    ST_READ
  } ssa_state_t;

  typedef struct packed {
    logic [2:0]                 command;
    logic [NEURON_W-1:0]        neuron;
    logic [SYN_IDX_W-1:0]       synapse;
    logic [COUNT_W-1:0]         fanout_len;
    logic signed [WEIGHT_W-1:0] weight;
    logic [MOD_W-1:0]           modulator;
    logic signed [TOTAL_W-1:0]  value;
  } ssa_req_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic [NEURON_W-1:0]       read_neuron;
  } ssa_rsp_t;

endpackage

### rtl/ssa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on ssa_pkg only by house convention; read returns old data on collision
module ssa_ram
  import ssa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/spike_synapse_accumulator.sv
// top level of the spike synapse accumulator
// depends on ssa_pkg, ssa_ram and spike_synapse_accumulator_macros.svh
//
// Commands arrive one request at a time on the in_ channel. Synapse writes,
// fan-out range writes and external-input writes complete in the cycle they
// are accepted. A read first reads the accumulator memory, then loads the
// output register once it is free, and its response waits in the output register,
// so the next request is taken while the response is still stalled. A spike
// accepts the request, reads the fan-out range, walks its synapses and drains
// the read-modify-write pipeline of the accumulator memory; with an empty range
// it returns to idle after the fan-out read. The synapse memory read port, one
// synapse per cycle, sets the pace of the walk. During the walk the
// accumulator of each target is read, added to (weight * modulator) >>> 14
// and written back with saturation; a write from the previous cycle is
// forwarded when the next synapse hits the same target. All memories power up
// unknown; nothing is cleared after reset, so every entry must be written
// before it is read.
module spike_synapse_accumulator
  import ssa_pkg::*;
#(
  parameter int NEURONS  = 1024,
  parameter int SYNAPSES = 16384
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssa_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output ssa_rsp_t out_rsp
);

`include "spike_synapse_accumulator_macros.svh"

  localparam int NW = $clog2(NEURONS);
  localparam int SW = $clog2(SYNAPSES);

  // control state
  ssa_state_t state_r, state_nxt;
  logic       b_vld_r, b_vld_nxt;     // synapse word ready this cycle
  logic       c_vld_r, c_vld_nxt;     // accumulator word ready this cycle
  logic       fwd_vld_r;              // accumulator written last cycle
  logic       out_valid_r, out_valid_nxt;

  // payload registers
  logic [WALK_W-1:0]        k_r, k_nxt;
  logic [WALK_W-1:0]        lim_r, lim_nxt;
  logic [MOD_W-1:0]         mod_r, mod_nxt;
  logic [NW-1:0]            rd_addr_r, rd_addr_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [NEURON_W-1:0]      rd_neuron_r, rd_neuron_nxt;
  logic [NW-1:0]            c_tgt_r;
  logic signed [PROD_W-1:0] c_prod_r;
  logic [NW-1:0]            fwd_addr_r;
  logic [TOTAL_W-1:0]       fwd_data_r;
  ssa_rsp_t                 out_rsp_r, out_rsp_nxt;

  // memory ports
  logic                  syn_we, fan_we, acc_we;
  logic [SW-1:0]         syn_waddr, syn_raddr;
  logic [NW-1:0]         fan_waddr, fan_raddr, acc_waddr, acc_raddr;
  logic [SYN_WORD_W-1:0] syn_rdata;
  logic [FAN_WORD_W-1:0] fan_rdata;
  logic [TOTAL_W-1:0]    acc_wdata, acc_rdata;

  // request decode
  logic accept, nrn_ok, syn_ok, set_we;

  // walk datapath
  logic [NEURON_W-1:0]        b_tgt;
  logic signed [WEIGHT_W-1:0] b_weight;
  logic signed [PROD_W-1:0]   b_prod;
  logic [SYN_IDX_W-1:0]       fan_start;
  logic [COUNT_W-1:0]         fan_count;
  logic [COUNT_W:0]           fan_end;
  logic [31:0]                fan_lim;
  logic signed [TOTAL_W-1:0]  acc_old;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [TOTAL_W:0]    acc_sum;
  logic [TOTAL_W-1:0]         acc_upd;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign nrn_ok    = (32'(in_req.neuron) < 32'(NEURONS));
  assign syn_ok    = (32'(in_req.synapse) < 32'(SYNAPSES));
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ---------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------

  // synapse table: {target, weight}
  assign syn_we    = accept && (in_req.command == CMD_WR_SYN) && syn_ok;
  assign syn_waddr = SW'(in_req.synapse);
  assign syn_raddr = SW'(k_r);

  ssa_ram #(.WIDTH(SYN_WORD_W), .DEPTH(SYNAPSES)) u_syn_ram (
    .clk     (clk),
    .wr_en   (syn_we),
    .wr_addr (syn_waddr),
    .wr_data ({in_req.neuron, in_req.weight}),
    .rd_addr (syn_raddr),
    .rd_data (syn_rdata)
  );

  // fan-out ranges: {start, count}
  assign fan_we    = accept && (in_req.command == CMD_WR_FAN) && nrn_ok;
  assign fan_waddr = NW'(in_req.neuron);
  assign fan_raddr = NW'(in_req.neuron);

  ssa_ram #(.WIDTH(FAN_WORD_W), .DEPTH(NEURONS)) u_fan_ram (
    .clk     (clk),
    .wr_en   (fan_we),
    .wr_addr (fan_waddr),
    .wr_data ({in_req.synapse, in_req.fanout_len}),
    .rd_addr (fan_raddr),
    .rd_data (fan_rdata)
  );

  // accumulators; the walk writes only outside idle, so the two writers never meet
  assign set_we    = accept && (in_req.command == CMD_SET_INPUT) && nrn_ok;
  assign acc_we    = c_vld_r || set_we;
  assign acc_waddr = c_vld_r ? c_tgt_r : NW'(in_req.neuron);
  assign acc_wdata = c_vld_r ? acc_upd : in_req.value;

  always_comb begin
    unique case (state_r)
      ST_IDLE: acc_raddr = NW'(in_req.neuron);
      ST_READ: acc_raddr = rd_addr_r;
      default: acc_raddr = NW'(b_tgt);
    endcase
  end

  ssa_ram #(.WIDTH(TOTAL_W), .DEPTH(NEURONS)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (acc_waddr),
    .wr_data (acc_wdata),
    .rd_addr (acc_raddr),
    .rd_data (acc_rdata)
  );

  // ---------------------------------------------------------------------
  // walk pipeline: issue synapse read, multiply, read-add-write accumulator
  // ---------------------------------------------------------------------

  assign b_tgt    = syn_rdata[SYN_WORD_W-1:WEIGHT_W];
  assign b_weight = $signed(syn_rdata[WEIGHT_W-1:0]);
  // weight is signed, modulator unsigned: extend both to the product width
  assign b_prod   = $signed({{(PROD_W-WEIGHT_W){b_weight[WEIGHT_W-1]}}, b_weight})
                  * $signed({{(PROD_W-MOD_W){1'b0}}, mod_r});

  assign c_vld_nxt = b_vld_r && (32'(b_tgt) < 32'(NEURONS));

  // last cycle's write has not reached the registered read yet
  assign acc_old = (fwd_vld_r && (fwd_addr_r == c_tgt_r)) ? $signed(fwd_data_r)
                                                           : $signed(acc_rdata);
  // arithmetic shift floors, matching the rounding toward minus infinity
  assign scaled  = c_prod_r[PROD_W-1:FRAC_SH];
  assign acc_sum = $signed({acc_old[TOTAL_W-1], acc_old})
                 + $signed({{(TOTAL_W+1-SCALED_W){scaled[SCALED_W-1]}}, scaled});

  always_comb begin
    priority if (acc_sum[TOTAL_W] == acc_sum[TOTAL_W-1]) begin
      acc_upd = acc_sum[TOTAL_W-1:0];
    end else if (acc_sum[TOTAL_W]) begin
      acc_upd = {1'b1, {(TOTAL_W-1){1'b0}}};
    end else begin
      acc_upd = {1'b0, {(TOTAL_W-1){1'b1}}};
    end
  end

  // fan-out end clipped to the table size
  assign fan_start = fan_rdata[FAN_WORD_W-1:COUNT_W];
  assign fan_count = fan_rdata[COUNT_W-1:0];
  assign fan_end   = {2'b00, fan_start} + {1'b0, fan_count};
  assign fan_lim   = (32'(fan_end) > 32'(SYNAPSES)) ? 32'(SYNAPSES) : 32'(fan_end);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------

  always_comb begin
    state_nxt     = state_r;
    b_vld_nxt     = 1'b0;
    k_nxt         = k_r;
    lim_nxt       = lim_r;
    mod_nxt       = mod_r;
    rd_addr_nxt   = rd_addr_r;
    rd_ok_nxt     = rd_ok_r;
    rd_neuron_nxt = rd_neuron_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_req.command == CMD_SPIKE) && nrn_ok) begin
            mod_nxt   = in_req.modulator;
            state_nxt = ST_FAN;
          end else if (in_req.command == CMD_READ) begin
            rd_addr_nxt   = NW'(in_req.neuron);
            rd_ok_nxt     = nrn_ok;
            rd_neuron_nxt = in_req.neuron;
            state_nxt     = ST_READ;
          end
        end
      end
      ST_FAN: begin
        k_nxt   = WALK_W'(fan_start);
        lim_nxt = WALK_W'(fan_lim);
        if (32'(fan_start) < fan_lim) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        b_vld_nxt = 1'b1;
        k_nxt     = k_r + WALK_W'(1);
        if ((k_r + WALK_W'(1)) == lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // leave once the last accumulator write is under way
        if (!b_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.total       = rd_ok_r ? $signed(acc_rdata) : '0;
          out_rsp_nxt.read_neuron = rd_neuron_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_vld_r     <= b_vld_nxt;
      c_vld_r     <= c_vld_nxt;
      fwd_vld_r   <= c_vld_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    lim_r       <= lim_nxt;
    mod_r       <= mod_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_neuron_r <= rd_neuron_nxt;
    c_tgt_r     <= NW'(b_tgt);
    c_prod_r    <= b_prod;
    fwd_addr_r  <= c_tgt_r;
    fwd_data_r  <= acc_upd;
    out_rsp_r   <= out_rsp_nxt;
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  `SSA_ASSERT_IMP(a_walk_in_range, clk, rst_n, state_r == ST_WALK, k_r < lim_r, "walk past limit")
  `SSA_ASSERT_IMP(a_acc_wr_in_walk, clk, rst_n, c_vld_r, state_r == ST_WALK || state_r == ST_DRAIN, "accumulator write outside walk")
  `SSA_ASSERT_IMP(a_syn_from_walk, clk, rst_n, b_vld_r, $past(state_r) == ST_WALK, "synapse word without issue")
  `SSA_ASSERT_NXT(a_rsp_from_read, clk, rst_n, !out_valid_r && state_r != ST_READ, !out_valid_r, "response without read")

endmodule
